[hdl/circle_circle_contact_assert.svh]
// Assertion macros for the circle contact pipeline checker.
// Depends on nothing; included by the checker file only.
`ifndef CIRCLE_CIRCLE_CONTACT_ASSERT_SVH
`define CIRCLE_CIRCLE_CONTACT_ASSERT_SVH

// Overlapping implication, checked outside reset.
`define CCC_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("circle contact check failed");

// Implication checked in the cycle after the antecedent.
`define CCC_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("circle contact check failed");

`endif

[hdl/ccc_pkg.sv]
// Shared constants and pipeline control type for the circle contact block.
// No dependencies.
package ccc_pkg;

  localparam int unsigned FRAC_W    = 16;
  localparam int unsigned NORM_W    = 18;
  localparam int unsigned DIV_STEPS = 18;

  localparam logic [FRAC_W-1:0] FRAC_MASK = 16'hFFFF;
  localparam logic [NORM_W-1:0] NORM_ONE  = 18'd65536;

  typedef struct packed {
    logic valid;
    logic advance;
  } pipe_ctl_t;

endpackage

[hdl/ccc_front.sv]
// Front stages: world centres, scaled radii, centre deltas and squared distance.
// Depends on ccc_pkg.
module ccc_front #(
  parameter int unsigned CW = 32
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  ccc_pkg::pipe_ctl_t     ctl_i,
  input  logic [31:0]            a_center_x_i,
  input  logic [31:0]            a_center_y_i,
  input  logic [31:0]            a_offset_x_i,
  input  logic [31:0]            a_offset_y_i,
  input  logic [30:0]            a_radius_i,
  input  logic [31:0]            a_scale_i,
  input  logic [31:0]            b_center_x_i,
  input  logic [31:0]            b_center_y_i,
  input  logic [31:0]            b_offset_x_i,
  input  logic [31:0]            b_offset_y_i,
  input  logic [30:0]            b_radius_i,
  input  logic [31:0]            b_scale_i,
  output logic                   valid_o,
  output logic [CW-1:0]          ax_o,
  output logic [CW-1:0]          ay_o,
  output logic [CW-1:0]          bx_o,
  output logic [CW-1:0]          by_o,
  output logic [CW-1:0]          ar_o,
  output logic [CW-1:0]          br_o,
  output logic                   dx_neg_o,
  output logic                   dy_neg_o,
  output logic [CW:0]            mx_o,
  output logic [CW:0]            my_o,
  output logic [2*CW+2:0]        sq_o
);
  import ccc_pkg::*;

  localparam int unsigned XW = ((CW > 33) ? CW : 33) + 1;
  localparam logic signed [XW-1:0] CMAX = {{(XW-CW+1){1'b0}}, {(CW-1){1'b1}}};
  localparam logic signed [XW-1:0] CMIN = ~CMAX;
  localparam logic signed [63:0]   RMAX = {{(65-CW){1'b0}}, {(CW-1){1'b1}}};
  localparam logic signed [63:0]   RMIN = ~RMAX;

  function automatic logic [CW-1:0] sat_sum(input logic [31:0] p, input logic [31:0] q);
    logic signed [XW-1:0] s;
    s = $signed({{(XW-32){p[31]}}, p}) + $signed({{(XW-32){q[31]}}, q});
    if (s > CMAX) begin
      s = CMAX;
    end else if (s < CMIN) begin
      s = CMIN;
    end
    return s[CW-1:0];
  endfunction

  function automatic logic [CW-1:0] sat_rad(input logic signed [63:0] p);
    logic signed [63:0] t;
    t = (p + (p[63] ? $signed({1'b0, FRAC_MASK}) : 64'sd0)) >>> FRAC_W;
    if (t > RMAX) begin
      t = RMAX;
    end else if (t < RMIN) begin
      t = RMIN;
    end
    return t[CW-1:0];
  endfunction

  // stage 1
  logic                v1_q;
  logic [CW-1:0]       ax1_q, ay1_q, bx1_q, by1_q;
  logic signed [63:0]  pa1_q, pb1_q;
  // stage 2
  logic                v2_q;
  logic [CW-1:0]       ax2_q, ay2_q, bx2_q, by2_q, ar2_q, br2_q;
  logic                dxn2_q, dyn2_q;
  logic [CW:0]         mx2_q, my2_q;
  // stage 3
  logic                v3_q;
  logic [CW-1:0]       ax3_q, ay3_q, bx3_q, by3_q, ar3_q, br3_q;
  logic                dxn3_q, dyn3_q;
  logic [CW:0]         mx3_q, my3_q;
  logic [2*CW+1:0]     sqx3_q, sqy3_q;
  // stage 4
  logic                v4_q;
  logic [2*CW+2:0]     sq4_q;
  logic [CW-1:0]       ax4_q, ay4_q, bx4_q, by4_q, ar4_q, br4_q;
  logic                dxn4_q, dyn4_q;
  logic [CW:0]         mx4_q, my4_q;

  logic signed [CW:0]  dx_d, dy_d;

  assign dx_d = $signed({bx1_q[CW-1], bx1_q}) - $signed({ax1_q[CW-1], ax1_q});
  assign dy_d = $signed({by1_q[CW-1], by1_q}) - $signed({ay1_q[CW-1], ay1_q});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else if (ctl_i.advance) begin
      v1_q <= ctl_i.valid;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.advance) begin
      ax1_q  <= sat_sum(a_center_x_i, a_offset_x_i);
      ay1_q  <= sat_sum(a_center_y_i, a_offset_y_i);
      bx1_q  <= sat_sum(b_center_x_i, b_offset_x_i);
      by1_q  <= sat_sum(b_center_y_i, b_offset_y_i);
      pa1_q  <= $signed({1'b0, a_radius_i}) * $signed(a_scale_i);
      pb1_q  <= $signed({1'b0, b_radius_i}) * $signed(b_scale_i);

      ax2_q  <= ax1_q;
      ay2_q  <= ay1_q;
      bx2_q  <= bx1_q;
      by2_q  <= by1_q;
      ar2_q  <= sat_rad(pa1_q);
      br2_q  <= sat_rad(pb1_q);
      dxn2_q <= dx_d[CW];
      dyn2_q <= dy_d[CW];
      mx2_q  <= dx_d[CW] ? (CW+1)'(-dx_d) : dx_d;
      my2_q  <= dy_d[CW] ? (CW+1)'(-dy_d) : dy_d;

      ax3_q  <= ax2_q;
      ay3_q  <= ay2_q;
      bx3_q  <= bx2_q;
      by3_q  <= by2_q;
      ar3_q  <= ar2_q;
      br3_q  <= br2_q;
      dxn3_q <= dxn2_q;
      dyn3_q <= dyn2_q;
      mx3_q  <= mx2_q;
      my3_q  <= my2_q;
      sqx3_q <= mx2_q * mx2_q;
      sqy3_q <= my2_q * my2_q;

      ax4_q  <= ax3_q;
      ay4_q  <= ay3_q;
      bx4_q  <= bx3_q;
      by4_q  <= by3_q;
      ar4_q  <= ar3_q;
      br4_q  <= br3_q;
      dxn4_q <= dxn3_q;
      dyn4_q <= dyn3_q;
      mx4_q  <= mx3_q;
      my4_q  <= my3_q;
      sq4_q  <= {1'b0, sqx3_q} + {1'b0, sqy3_q};
    end
  end

  assign valid_o  = v4_q;
  assign ax_o     = ax4_q;
  assign ay_o     = ay4_q;
  assign bx_o     = bx4_q;
  assign by_o     = by4_q;
  assign ar_o     = ar4_q;
  assign br_o     = br4_q;
  assign dx_neg_o = dxn4_q;
  assign dy_neg_o = dyn4_q;
  assign mx_o     = mx4_q;
  assign my_o     = my4_q;
  assign sq_o     = sq4_q;

endmodule

[hdl/ccc_sqrt.sv]
// Pipelined integer square root, one result bit per register stage.
// Depends on ccc_pkg.
module ccc_sqrt #(
  parameter int unsigned CW     = 32,
  parameter int unsigned SIDE_W = 8
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  ccc_pkg::pipe_ctl_t ctl_i,
  input  logic [2*CW+2:0]    sq_i,
  input  logic [SIDE_W-1:0]  side_i,
  output logic               valid_o,
  output logic [CW+1:0]      root_o,
  output logic [SIDE_W-1:0]  side_o
);
  import ccc_pkg::*;

  localparam int unsigned QB = CW + 2;
  localparam int unsigned SB = 2 * QB;
  localparam int unsigned RW = QB + 2;

  logic              v_q    [QB];
  logic [RW-1:0]     rem_q  [QB];
  logic [QB-1:0]     root_q [QB];
  logic [SB-1:0]     s_q    [QB];
  logic [SIDE_W-1:0] side_q [QB];

  for (genvar k = 0; k < QB; k++) begin : g_stage
    logic              v_in;
    logic [RW-1:0]     rem_in;
    logic [QB-1:0]     root_in;
    logic [SB-1:0]     s_in;
    logic [SIDE_W-1:0] side_in;
    logic [RW-1:0]     rnx;
    logic [RW-1:0]     trial;
    logic              ge;

    if (k == 0) begin : g_first
      assign v_in    = ctl_i.valid;
      assign rem_in  = '0;
      assign root_in = '0;
      assign s_in    = {1'b0, sq_i};
      assign side_in = side_i;
    end else begin : g_next
      assign v_in    = v_q[k-1];
      assign rem_in  = rem_q[k-1];
      assign root_in = root_q[k-1];
      assign s_in    = s_q[k-1];
      assign side_in = side_q[k-1];
    end

    // bring down the next pair of radicand bits and try the next root bit
    assign rnx   = {rem_in[RW-3:0], s_in[SB-1-2*k -: 2]};
    assign trial = {root_in, 2'b01};
    assign ge    = (rnx >= trial);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k] <= 1'b0;
      end else if (ctl_i.advance) begin
        v_q[k] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (ctl_i.advance) begin
        rem_q[k]  <= ge ? rnx - trial : rnx;
        root_q[k] <= {root_in[QB-2:0], ge};
        s_q[k]    <= s_in;
        side_q[k] <= side_in;
      end
    end
  end

  assign valid_o = v_q[QB-1];
  assign root_o  = root_q[QB-1];
  assign side_o  = side_q[QB-1];

endmodule

[hdl/ccc_div.sv]
// Pipelined restoring divider for the two normal components, one quotient bit a stage.
// Depends on ccc_pkg.
module ccc_div #(
  parameter int unsigned CW     = 32,
  parameter int unsigned SIDE_W = 8
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  ccc_pkg::pipe_ctl_t         ctl_i,
  input  logic [CW+1:0]              dist_i,
  input  logic [CW:0]                mx_i,
  input  logic [CW:0]                my_i,
  input  logic [SIDE_W-1:0]          side_i,
  output logic                       valid_o,
  output logic [CW+1:0]              dist_o,
  output logic [ccc_pkg::NORM_W-1:0] qx_o,
  output logic [ccc_pkg::NORM_W-1:0] qy_o,
  output logic [SIDE_W-1:0]          side_o
);
  import ccc_pkg::*;

  localparam int unsigned QB   = CW + 2;
  localparam int unsigned NB   = DIV_STEPS;
  localparam int unsigned DW   = CW + 1 + FRAC_W;
  localparam int unsigned CMPW = QB + NB - 1;

  logic              v_q    [NB];
  logic [QB-1:0]     dist_q [NB];
  logic [DW-1:0]     rx_q   [NB];
  logic [DW-1:0]     ry_q   [NB];
  logic [NB-1:0]     qx_q   [NB];
  logic [NB-1:0]     qy_q   [NB];
  logic [SIDE_W-1:0] side_q [NB];

  for (genvar k = 0; k < NB; k++) begin : g_stage
    logic              v_in;
    logic [QB-1:0]     dist_in;
    logic [DW-1:0]     rx_in, ry_in;
    logic [NB-1:0]     qx_in, qy_in;
    logic [SIDE_W-1:0] side_in;
    logic [CMPW-1:0]   sh;
    logic              gex, gey;

    if (k == 0) begin : g_first
      assign v_in    = ctl_i.valid;
      assign dist_in = dist_i;
      assign rx_in   = {mx_i, {FRAC_W{1'b0}}};
      assign ry_in   = {my_i, {FRAC_W{1'b0}}};
      assign qx_in   = '0;
      assign qy_in   = '0;
      assign side_in = side_i;
    end else begin : g_next
      assign v_in    = v_q[k-1];
      assign dist_in = dist_q[k-1];
      assign rx_in   = rx_q[k-1];
      assign ry_in   = ry_q[k-1];
      assign qx_in   = qx_q[k-1];
      assign qy_in   = qy_q[k-1];
      assign side_in = side_q[k-1];
    end

    assign sh  = {{(NB-1){1'b0}}, dist_in} << (NB - 1 - k);
    assign gex = (sh <= {{(CMPW-DW){1'b0}}, rx_in});
    assign gey = (sh <= {{(CMPW-DW){1'b0}}, ry_in});

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k] <= 1'b0;
      end else if (ctl_i.advance) begin
        v_q[k] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (ctl_i.advance) begin
        dist_q[k] <= dist_in;
        rx_q[k]   <= gex ? rx_in - sh[DW-1:0] : rx_in;
        ry_q[k]   <= gey ? ry_in - sh[DW-1:0] : ry_in;
        qx_q[k]   <= {qx_in[NB-2:0], gex};
        qy_q[k]   <= {qy_in[NB-2:0], gey};
        side_q[k] <= side_in;
      end
    end
  end

  assign valid_o = v_q[NB-1];
  assign dist_o  = dist_q[NB-1];
  assign side_o  = side_q[NB-1];
  // cap at one
  assign qx_o = (qx_q[NB-1] > NORM_ONE) ? NORM_ONE : qx_q[NB-1];
  assign qy_o = (qy_q[NB-1] > NORM_ONE) ? NORM_ONE : qy_q[NB-1];

endmodule

[hdl/ccc_back.sv]
// Back stages: case decision, depth, rim points and the output register.
// Depends on ccc_pkg.
module ccc_back #(
  parameter int unsigned CW = 32
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  ccc_pkg::pipe_ctl_t         ctl_i,
  input  logic [CW+1:0]              dist_i,
  input  logic [ccc_pkg::NORM_W-1:0] qx_i,
  input  logic [ccc_pkg::NORM_W-1:0] qy_i,
  input  logic [CW-1:0]              ax_i,
  input  logic [CW-1:0]              ay_i,
  input  logic [CW-1:0]              bx_i,
  input  logic [CW-1:0]              by_i,
  input  logic [CW-1:0]              ar_i,
  input  logic [CW-1:0]              br_i,
  input  logic                       dx_neg_i,
  input  logic                       dy_neg_i,
  output logic                       valid_o,
  output logic                       hit_o,
  output logic [31:0]                point_a_x_o,
  output logic [31:0]                point_a_y_o,
  output logic [31:0]                point_b_x_o,
  output logic [31:0]                point_b_y_o,
  output logic [30:0]                depth_o,
  output logic [17:0]                normal_x_o,
  output logic [17:0]                normal_y_o
);
  import ccc_pkg::*;

  localparam int unsigned EW = ((CW + 3) > 33) ? (CW + 3) : 33;
  localparam int unsigned PRW = CW + NORM_W;
  localparam int unsigned OS = (CW < 32) ? CW : 32;
  localparam logic signed [EW-1:0] DMAX = {{(EW-31){1'b0}}, {31{1'b1}}};
  localparam logic signed [EW-1:0] PMAX = {{(EW-OS+1){1'b0}}, {(OS-1){1'b1}}};
  localparam logic signed [EW-1:0] PMIN = ~PMAX;

  function automatic logic signed [EW-1:0] ext_c(input logic [CW-1:0] v);
    return $signed({{(EW-CW){v[CW-1]}}, v});
  endfunction

  // rim point: centre plus or minus the product truncated toward zero
  function automatic logic [31:0] rim(input logic [CW-1:0] c,
                                      input logic signed [PRW-1:0] p,
                                      input logic plus);
    logic signed [PRW-1:0] off;
    logic signed [EW-1:0]  offe;
    logic signed [EW-1:0]  s;
    off  = (p + (p[PRW-1] ? $signed({1'b0, FRAC_MASK}) : '0)) >>> FRAC_W;
    offe = $signed({{(EW-CW-2){off[CW+1]}}, off[CW+1:0]});
    s    = plus ? ext_c(c) + offe : ext_c(c) - offe;
    if (s > PMAX) begin
      s = PMAX;
    end else if (s < PMIN) begin
      s = PMIN;
    end
    return s[31:0];
  endfunction

  logic signed [EW-1:0]     dist_e, ar_e, br_e, sum_e, dif_e, adif_e, big_e, dep_e;
  logic                     hit_d, cont_d;
  logic signed [NORM_W-1:0] nx_d, ny_d;

  logic                     v1_q, hit1_q, cont1_q, sg1_q;
  logic [30:0]              dep1_q;
  logic signed [NORM_W-1:0] nx1_q, ny1_q;
  logic [CW-1:0]            ax1_q, ay1_q, bx1_q, by1_q;
  logic signed [PRW-1:0]    pax1_q, pay1_q, pbx1_q, pby1_q;

  logic                     v2_q, hit2_q;
  logic [31:0]              pax2_q, pay2_q, pbx2_q, pby2_q;
  logic [30:0]              dep2_q;
  logic [17:0]              nx2_q, ny2_q;

  always_comb begin
    dist_e = $signed({{(EW-CW-2){1'b0}}, dist_i});
    ar_e   = ext_c(ar_i);
    br_e   = ext_c(br_i);
    sum_e  = ar_e + br_e;
    dif_e  = ar_e - br_e;
    adif_e = dif_e[EW-1] ? -dif_e : dif_e;
    big_e  = (ar_e > br_e) ? ar_e : br_e;
    hit_d  = !((dist_e >= sum_e) || (dist_e <= adif_e));
    cont_d = (dist_e < big_e);
    dep_e  = cont_d ? dist_e - adif_e : sum_e - dist_e;
    if (dep_e[EW-1]) begin
      dep_e = '0;
    end else if (dep_e > DMAX) begin
      dep_e = DMAX;
    end
    nx_d = dx_neg_i ? -$signed(qx_i) : $signed(qx_i);
    ny_d = dy_neg_i ? -$signed(qy_i) : $signed(qy_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else if (ctl_i.advance) begin
      v1_q <= ctl_i.valid;
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.advance) begin
      hit1_q  <= hit_d;
      cont1_q <= cont_d;
      sg1_q   <= ($signed(ar_i) > $signed(br_i));
      dep1_q  <= dep_e[30:0];
      nx1_q   <= nx_d;
      ny1_q   <= ny_d;
      ax1_q   <= ax_i;
      ay1_q   <= ay_i;
      bx1_q   <= bx_i;
      by1_q   <= by_i;
      pax1_q  <= nx_d * $signed(ar_i);
      pay1_q  <= ny_d * $signed(ar_i);
      pbx1_q  <= nx_d * $signed(br_i);
      pby1_q  <= ny_d * $signed(br_i);

      // zero every field on a miss
      hit2_q  <= hit1_q;
      pax2_q  <= hit1_q ? rim(ax1_q, pax1_q, !cont1_q || sg1_q) : '0;
      pay2_q  <= hit1_q ? rim(ay1_q, pay1_q, !cont1_q || sg1_q) : '0;
      pbx2_q  <= hit1_q ? rim(bx1_q, pbx1_q, cont1_q && sg1_q) : '0;
      pby2_q  <= hit1_q ? rim(by1_q, pby1_q, cont1_q && sg1_q) : '0;
      dep2_q  <= hit1_q ? dep1_q : '0;
      nx2_q   <= hit1_q ? (cont1_q ? -nx1_q : nx1_q) : '0;
      ny2_q   <= hit1_q ? (cont1_q ? -ny1_q : ny1_q) : '0;
    end
  end

  assign valid_o     = v2_q;
  assign hit_o       = hit2_q;
  assign point_a_x_o = pax2_q;
  assign point_a_y_o = pay2_q;
  assign point_b_x_o = pbx2_q;
  assign point_b_y_o = pby2_q;
  assign depth_o     = dep2_q;
  assign normal_x_o  = nx2_q;
  assign normal_y_o  = ny2_q;

endmodule

[hdl/circle_circle_contact.sv]
// Pipeline, from input transfer to result:
//   4 front stages, COORD_WIDTH + 2 root stages, 18 divide stages, 2 back stages.
// Throughput: one pair per cycle; the whole pipe advances together, set by the
//   output register: it holds when a result waits and out_ready_i is low.
// Reset: rst_ni clears every stage valid bit at once; payload registers are not reset.
module circle_circle_contact #(
  parameter int unsigned COORD_WIDTH = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [31:0] a_center_x_i,
  input  logic [31:0] a_center_y_i,
  input  logic [31:0] a_offset_x_i,
  input  logic [31:0] a_offset_y_i,
  input  logic [30:0] a_radius_i,
  input  logic [31:0] a_scale_i,
  input  logic [31:0] b_center_x_i,
  input  logic [31:0] b_center_y_i,
  input  logic [31:0] b_offset_x_i,
  input  logic [31:0] b_offset_y_i,
  input  logic [30:0] b_radius_i,
  input  logic [31:0] b_scale_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        hit_o,
  output logic [31:0] point_a_x_o,
  output logic [31:0] point_a_y_o,
  output logic [31:0] point_b_x_o,
  output logic [31:0] point_b_y_o,
  output logic [30:0] depth_o,
  output logic [17:0] normal_x_o,
  output logic [17:0] normal_y_o
);
  import ccc_pkg::*;

  localparam int unsigned CW  = COORD_WIDTH;
  localparam int unsigned QB  = CW + 2;
  // centres and radii, the two delta signs, then (sqrt side only) the magnitudes
  localparam int unsigned SD_W = 6 * CW + 2;
  localparam int unsigned SQ_W = SD_W + 2 * (CW + 1);

  // Advance the whole pipe whenever the output register is free or being drained.
  logic advance;
  assign advance    = !out_valid_o || out_ready_i;
  assign in_ready_o = advance;

  pipe_ctl_t ctl_front, ctl_sqrt, ctl_div, ctl_back;

  logic              f_valid;
  logic [CW-1:0]     f_ax, f_ay, f_bx, f_by, f_ar, f_br;
  logic              f_dxn, f_dyn;
  logic [CW:0]       f_mx, f_my;
  logic [2*CW+2:0]   f_sq;

  logic              s_valid;
  logic [QB-1:0]     s_root;
  logic [SQ_W-1:0]   s_side_in, s_side_out;

  logic              d_valid;
  logic [QB-1:0]     d_dist;
  logic [NORM_W-1:0] d_qx, d_qy;
  logic [SD_W-1:0]   d_side_in, d_side_out;

  assign ctl_front = '{valid: in_valid_i, advance: advance};
  assign ctl_sqrt  = '{valid: f_valid,    advance: advance};
  assign ctl_div   = '{valid: s_valid,    advance: advance};
  assign ctl_back  = '{valid: d_valid,    advance: advance};

  // World centres, scaled radii and the squared centre distance.
  ccc_front #(.CW(CW)) u_front (
    .clk_i, .rst_ni,
    .ctl_i        (ctl_front),
    .a_center_x_i, .a_center_y_i, .a_offset_x_i, .a_offset_y_i,
    .a_radius_i,   .a_scale_i,
    .b_center_x_i, .b_center_y_i, .b_offset_x_i, .b_offset_y_i,
    .b_radius_i,   .b_scale_i,
    .valid_o      (f_valid),
    .ax_o         (f_ax),
    .ay_o         (f_ay),
    .bx_o         (f_bx),
    .by_o         (f_by),
    .ar_o         (f_ar),
    .br_o         (f_br),
    .dx_neg_o     (f_dxn),
    .dy_neg_o     (f_dyn),
    .mx_o         (f_mx),
    .my_o         (f_my),
    .sq_o         (f_sq)
  );

  assign s_side_in = {f_ax, f_ay, f_bx, f_by, f_ar, f_br, f_dxn, f_dyn, f_mx, f_my};

  // Exact floor square root of the squared distance.
  ccc_sqrt #(.CW(CW), .SIDE_W(SQ_W)) u_sqrt (
    .clk_i, .rst_ni,
    .ctl_i   (ctl_sqrt),
    .sq_i    (f_sq),
    .side_i  (s_side_in),
    .valid_o (s_valid),
    .root_o  (s_root),
    .side_o  (s_side_out)
  );

  assign d_side_in = s_side_out[SQ_W-1 -: SD_W];

  // Unit direction magnitudes; the result is don't-care at zero distance,
  // which is always reported as no contact.
  ccc_div #(.CW(CW), .SIDE_W(SD_W)) u_div (
    .clk_i, .rst_ni,
    .ctl_i   (ctl_div),
    .dist_i  (s_root),
    .mx_i    (s_side_out[2*CW+1 -: CW+1]),
    .my_i    (s_side_out[CW:0]),
    .side_i  (d_side_in),
    .valid_o (d_valid),
    .dist_o  (d_dist),
    .qx_o    (d_qx),
    .qy_o    (d_qy),
    .side_o  (d_side_out)
  );

  // Contact case, depth, rim points; ends in the output register.
  ccc_back #(.CW(CW)) u_back (
    .clk_i, .rst_ni,
    .ctl_i       (ctl_back),
    .dist_i      (d_dist),
    .qx_i        (d_qx),
    .qy_i        (d_qy),
    .ax_i        (d_side_out[6*CW+1 -: CW]),
    .ay_i        (d_side_out[5*CW+1 -: CW]),
    .bx_i        (d_side_out[4*CW+1 -: CW]),
    .by_i        (d_side_out[3*CW+1 -: CW]),
    .ar_i        (d_side_out[2*CW+1 -: CW]),
    .br_i        (d_side_out[CW+1 -: CW]),
    .dx_neg_i    (d_side_out[1]),
    .dy_neg_i    (d_side_out[0]),
    .valid_o     (out_valid_o),
    .hit_o,
    .point_a_x_o, .point_a_y_o, .point_b_x_o, .point_b_y_o,
    .depth_o,
    .normal_x_o,  .normal_y_o
  );

endmodule

[hdl/ccc_checker.sv]
// Port-level checker for circle_circle_contact, bound to the top level.
// Depends on circle_circle_contact_assert.svh.
`include "circle_circle_contact_assert.svh"

module ccc_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic        hit_o,
  input logic [31:0] point_a_x_o,
  input logic [31:0] point_a_y_o,
  input logic [31:0] point_b_x_o,
  input logic [31:0] point_b_y_o,
  input logic [30:0] depth_o,
  input logic [17:0] normal_x_o,
  input logic [17:0] normal_y_o
);

  // hold a result that has not been taken
  `CCC_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i, out_valid_o)

  // a miss carries all-zero fields
  `CCC_ASSERT_NOW(a_miss_zero, clk_i, rst_ni, out_valid_o && !hit_o, (point_a_x_o == 32'd0) && (point_a_y_o == 32'd0) && (point_b_x_o == 32'd0) && (point_b_y_o == 32'd0) && (depth_o == 31'd0) && (normal_x_o == 18'd0) && (normal_y_o == 18'd0))

  // a contact always has some penetration
  `CCC_ASSERT_NOW(a_hit_depth, clk_i, rst_ni, out_valid_o && hit_o, depth_o != 31'd0)

  // normal components stay within one
  `CCC_ASSERT_NOW(a_norm_range, clk_i, rst_ni, out_valid_o, ($signed(normal_x_o) <= 18'sd65536) && ($signed(normal_x_o) >= -18'sd65536) && ($signed(normal_y_o) <= 18'sd65536) && ($signed(normal_y_o) >= -18'sd65536))

endmodule

bind circle_circle_contact ccc_checker u_ccc_checker (.*);

[test/circle_circle_contact_tb.sv]
// Self-checking testbench for circle_circle_contact: drives circle pairs over a
// valid/ready channel, predicts each contact result and checks it field by field.
// Depends on the circle_circle_contact RTL only.
`timescale 1ns / 100ps

module circle_circle_contact_tb;

  localparam int unsigned COORD_W    = 32;
  localparam int unsigned PIPE_DEPTH = COORD_W + 26;
  localparam int unsigned CYCLE_CAP  = 600000;
  localparam longint      ONE        = 65536;

  typedef struct packed {
    logic [31:0] a_cx, a_cy, a_ox, a_oy;
    logic [30:0] a_r;
    logic [31:0] a_s;
    logic [31:0] b_cx, b_cy, b_ox, b_oy;
    logic [30:0] b_r;
    logic [31:0] b_s;
  } pair_t;

  typedef struct packed {
    logic        hit;
    logic [31:0] pa_x, pa_y, pb_x, pb_y;
    logic [30:0] depth;
    logic [17:0] n_x, n_y;
  } contact_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  pair_t       pair_q = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  contact_t    got;

  contact_t    expected_contacts[$];
  int          mismatches = 0;
  int          results_seen = 0;
  int          hits_seen = 0;
  int          pairs_sent = 0;
  int          cycles = 0;
  int          send_idle_pct = 0;
  int          stall_pct = 0;
  int          hold_cycles = 0;
  int          held = 0;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  circle_circle_contact #(.COORD_WIDTH(COORD_W)) i_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .a_center_x_i(pair_q.a_cx),
    .a_center_y_i(pair_q.a_cy),
    .a_offset_x_i(pair_q.a_ox),
    .a_offset_y_i(pair_q.a_oy),
    .a_radius_i  (pair_q.a_r),
    .a_scale_i   (pair_q.a_s),
    .b_center_x_i(pair_q.b_cx),
    .b_center_y_i(pair_q.b_cy),
    .b_offset_x_i(pair_q.b_ox),
    .b_offset_y_i(pair_q.b_oy),
    .b_radius_i  (pair_q.b_r),
    .b_scale_i   (pair_q.b_s),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .hit_o       (got.hit),
    .point_a_x_o (got.pa_x),
    .point_a_y_o (got.pa_y),
    .point_b_x_o (got.pb_x),
    .point_b_y_o (got.pb_y),
    .depth_o     (got.depth),
    .normal_x_o  (got.n_x),
    .normal_y_o  (got.n_y)
  );

  // ---------------------------------------------------------------------------
  // Contact predictor
  // ---------------------------------------------------------------------------

  function automatic longint sat_coord(longint v);
    longint hi;
    hi = (longint'(1) <<< (COORD_W - 1)) - 1;
    if (v > hi) return hi;
    if (v < -hi - 1) return -hi - 1;
    return v;
  endfunction

  // Radius times x scale, truncated toward zero, kept signed.
  function automatic longint scaled_radius(logic [30:0] r, logic [31:0] s);
    return sat_coord((longint'({1'b0, r}) * longint'($signed(s))) / ONE);
  endfunction

  // One component of the unit direction, magnitude capped at one.
  function automatic longint unit_part(longint v, longint dlen);
    logic [127:0] mag, q;
    mag = (v < 0) ? 128'(-v) : 128'(v);
    q = (mag << 16) / 128'(dlen);
    if (q > 128'(ONE)) q = 128'(ONE);
    return (v < 0) ? -longint'(q) : longint'(q);
  endfunction

  // Centre moved along the normal by the radius; clamp to 32 signed bits.
  function automatic logic [31:0] rim_point(longint c, longint n, longint r, bit plus);
    longint off, p;
    off = (n * r) / ONE;
    p = plus ? c + off : c - off;
    p = sat_coord(p);
    if (p > 64'sh7FFF_FFFF) p = 64'sh7FFF_FFFF;
    if (p < -64'sh8000_0000) p = -64'sh8000_0000;
    return p[31:0];
  endfunction

  function automatic contact_t predict_contact(pair_t p);
    longint       ax, ay, ar, bx, by, br, dx, dy, dlen, sum, diff, big, nx, ny, dep;
    logic [127:0] sq, t, mx, my;
    bit           outward;
    contact_t     c;
    c  = '0;
    ax = sat_coord(longint'($signed(p.a_cx)) + longint'($signed(p.a_ox)));
    ay = sat_coord(longint'($signed(p.a_cy)) + longint'($signed(p.a_oy)));
    bx = sat_coord(longint'($signed(p.b_cx)) + longint'($signed(p.b_ox)));
    by = sat_coord(longint'($signed(p.b_cy)) + longint'($signed(p.b_oy)));
    ar = scaled_radius(p.a_r, p.a_s);
    br = scaled_radius(p.b_r, p.b_s);
    dx = bx - ax;
    dy = by - ay;
    mx = (dx < 0) ? 128'(-dx) : 128'(dx);
    my = (dy < 0) ? 128'(-dy) : 128'(dy);
    sq = mx * mx + my * my;
    // Exact integer square root, one bit at a time.
    dlen = 0;
    for (int b = 51; b >= 0; b--) begin
      t = 128'(dlen) | (128'(1) << b);
      if (t * t <= sq) dlen = longint'(t);
    end
    sum  = ar + br;
    diff = (ar > br) ? ar - br : br - ar;
    big  = (ar > br) ? ar : br;
    // Apart, or one circle wholly inside the other: no contact.
    if (dlen >= sum || dlen <= diff) return c;
    nx = unit_part(dx, dlen);
    ny = unit_part(dy, dlen);
    if (dlen >= big) begin
      c.pa_x = rim_point(ax, nx, ar, 1'b1);
      c.pa_y = rim_point(ay, ny, ar, 1'b1);
      c.pb_x = rim_point(bx, nx, br, 1'b0);
      c.pb_y = rim_point(by, ny, br, 1'b0);
      dep = sum - dlen;
    end else begin
      // Partly contained: both rims move the same way, normal flips.
      outward = (ar > br);
      c.pa_x = rim_point(ax, nx, ar, outward);
      c.pa_y = rim_point(ay, ny, ar, outward);
      c.pb_x = rim_point(bx, nx, br, outward);
      c.pb_y = rim_point(by, ny, br, outward);
      dep = dlen - diff;
      nx = -nx;
      ny = -ny;
    end
    if (dep < 0) dep = 0;
    if (dep > 64'sh7FFF_FFFF) dep = 64'sh7FFF_FFFF;
    c.hit   = 1'b1;
    c.depth = dep[30:0];
    c.n_x   = nx[17:0];
    c.n_y   = ny[17:0];
    return c;
  endfunction

  // ---------------------------------------------------------------------------
  // Sender: hold valid and payload until the transfer, idle between pairs
  // ---------------------------------------------------------------------------

  task automatic send_pair(pair_t p);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    pair_q   <= p;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    expected_contacts.push_back(predict_contact(p));
    pairs_sent++;
  endtask

  task automatic end_stream();
    in_valid <= 1'b0;
    @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Receiver: random stalls, plus one long hold-off counted here
  // ---------------------------------------------------------------------------

  always @(posedge clk) begin
    if (held < hold_cycles) begin
      out_ready <= 1'b0;
      held <= held + 1;
    end else begin
      out_ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // Check every result transfer against the oldest prediction.
  always @(posedge clk) begin
    contact_t    want;
    string       bad;
    if (rst_n && out_valid && out_ready) begin
      results_seen++;
      if (got.hit) hits_seen++;
      if (expected_contacts.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("ERROR: result with nothing expected: %h", got);
      end else begin
        want = expected_contacts.pop_front();
        bad = "";
        if (got.hit !== want.hit) bad = {bad, " hit"};
        if (got.pa_x !== want.pa_x) bad = {bad, " point_a_x"};
        if (got.pa_y !== want.pa_y) bad = {bad, " point_a_y"};
        if (got.pb_x !== want.pb_x) bad = {bad, " point_b_x"};
        if (got.pb_y !== want.pb_y) bad = {bad, " point_b_y"};
        if (got.depth !== want.depth) bad = {bad, " depth"};
        if (got.n_x !== want.n_x) bad = {bad, " normal_x"};
        if (got.n_y !== want.n_y) bad = {bad, " normal_y"};
        if (bad != "") begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("ERROR: result %0d differs in%s", results_seen, bad);
            $display("  expected hit=%b pa=(%h,%h) pb=(%h,%h) depth=%h n=(%h,%h)",
                     want.hit, want.pa_x, want.pa_y, want.pb_x, want.pb_y,
                     want.depth, want.n_x, want.n_y);
            $display("  actual   hit=%b pa=(%h,%h) pb=(%h,%h) depth=%h n=(%h,%h)",
                     got.hit, got.pa_x, got.pa_y, got.pb_x, got.pb_y,
                     got.depth, got.n_x, got.n_y);
          end
        end
      end
    end
  end

  // Watchdog: drop the run if it hangs.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_CAP) begin
      $display("ERROR: timeout after %0d cycles", cycles);
      $display("circle_circle_contact_tb NOT OK");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------

  function automatic logic [31:0] rand_around(int unsigned span);
    return 32'($urandom_range(2 * span)) - 32'(span);
  endfunction

  function automatic logic [31:0] rand_scale();
    int unsigned pick;
    pick = $urandom_range(9);
    if (pick < 6) return 32'h0001_0000;
    if (pick < 8) return rand_around(32'h0002_0000);
    return -32'($urandom_range(32'h0002_0000));
  endfunction

  // Mostly plausible geometry (circles within +/-20 units, radii up to 25);
  // some pairs are wholly random bits.
  function automatic pair_t make_pair();
    pair_t p;
    if ($urandom_range(99) < 15) begin
      p = ($bits(pair_t))'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                            $urandom, $urandom, $urandom, $urandom, $urandom, $urandom});
    end else begin
      p.a_cx = rand_around(10 << 16);
      p.a_cy = rand_around(10 << 16);
      p.a_ox = rand_around(10 << 16);
      p.a_oy = rand_around(10 << 16);
      p.a_r  = 31'($urandom_range(25 << 16));
      p.a_s  = rand_scale();
      p.b_cx = rand_around(10 << 16);
      p.b_cy = rand_around(10 << 16);
      p.b_ox = rand_around(10 << 16);
      p.b_oy = rand_around(10 << 16);
      p.b_r  = 31'($urandom_range(25 << 16));
      p.b_s  = rand_scale();
    end
    return p;
  endfunction

  // Compact builder: centre, zero offset, radius, unit scale.
  function automatic pair_t circles(int ax, int ay, int ar, int bx, int by, int br);
    pair_t p;
    p = '0;
    p.a_cx = ax; p.a_cy = ay; p.a_r = 31'(ar); p.a_s = 32'h0001_0000;
    p.b_cx = bx; p.b_cy = by; p.b_r = 31'(br); p.b_s = 32'h0001_0000;
    return p;
  endfunction

  task automatic wait_drained();
    while (expected_contacts.size() != 0) @(posedge clk);
    repeat (PIPE_DEPTH + 10) @(posedge clk);
  endtask

  task automatic test_directed();
    pair_t p;
    send_idle_pct = 0;
    stall_pct = 0;
    send_pair('0);                                          // coincident, zero radii
    send_pair(circles(0, 0, 3 << 16, 0, 0, 2 << 16));       // coincident centres
    send_pair(circles(0, 0, 2 << 16, 3 << 16, 0, 2 << 16)); // separate overlap, x
    send_pair(circles(0, 0, 2 << 16, 0, -3 << 16, 2 << 16));// separate overlap, -y
    send_pair(circles(0, 0, 5 << 16, 2 << 16, 1 << 16, 4 << 16)); // A contains part of B
    send_pair(circles(0, 0, 3 << 16, -1 << 16, 2 << 16, 5 << 16)); // B larger
    send_pair(circles(0, 0, 1 << 16, 9 << 16, 0, 1 << 16)); // apart
    send_pair(circles(0, 0, 2 << 16, 4 << 16, 0, 2 << 16)); // just touching
    send_pair(circles(0, 0, 9 << 16, 1 << 16, 0, 1 << 16)); // fully inside
    send_pair(circles(0, 0, 2 << 16, 2 << 16, 0, 2 << 16)); // d equals radius
    p = circles(0, 0, 2 << 16, 3 << 16, 3 << 16, 3 << 16);
    p.a_s = 32'hFFFF_0000;                                  // negative scale on A
    send_pair(p);
    p.b_s = 32'hFFFE_0000;                                  // both negative
    send_pair(p);
    p = '1;                                                 // every bit high
    send_pair(p);
    p = '0;
    p.a_cx = 32'h7FFF_FFFF; p.a_ox = 32'h7FFF_FFFF;         // saturating sums
    p.b_cx = 32'h8000_0000; p.b_ox = 32'h8000_0000;
    p.a_r = '1; p.b_r = '1; p.a_s = 32'h7FFF_FFFF; p.b_s = 32'h7FFF_FFFF;
    send_pair(p);
    p.a_s = 32'h8000_0000; p.b_s = 32'h8000_0000;           // most negative scale
    send_pair(p);
    p = circles(32'h7FF0_0000, 32'h8010_0000, 30 << 16,
                32'h7FF0_0000 + (20 << 16), 32'h8010_0000, 30 << 16);
    send_pair(p);                                           // centres near opposite x limits
    p = circles(0, 0, 31'h7FFF_FFFF, 32'h4000_0000, 32'h4000_0000, 31'h7FFF_FFFF);
    send_pair(p);                                           // huge radii
    send_pair(circles(0, 0, 1, 1, 1, 1));                   // tiny raw values
    end_stream();
    wait_drained();
  endtask

  task automatic test_random(int n, int idle, int stall);
    send_idle_pct = idle;
    stall_pct = stall;
    repeat (n) begin
      // Leave stretches without any idling inside each phase.
      if ($urandom_range(99) < 3) send_idle_pct = (send_idle_pct == 0) ? idle : 0;
      send_pair(make_pair());
    end
    end_stream();
    wait_drained();
  endtask

  // Receiver holds off long enough for the pipe to fill and stall the input.
  task automatic test_backpressure();
    send_idle_pct = 0;
    stall_pct = 0;
    hold_cycles <= 3 * PIPE_DEPTH + 100;
    repeat (200) send_pair(make_pair());
    end_stream();
    wait_drained();
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_random(420, 0, 0);
    test_random(420, 64, 0);
    test_random(420, 0, 64);
    test_random(420, 24, 24);
    test_backpressure();
    if (expected_contacts.size() != 0) begin
      mismatches++;
      $display("ERROR: %0d results never arrived", expected_contacts.size());
    end
    $display("Sent %0d circle pairs, checked %0d results (%0d contacts), %0d mismatches",
             pairs_sent, results_seen, hits_seen, mismatches);
    $display("Covered overlap, containment, separation, negative scale, saturation, stalls");
    if (mismatches == 0) begin
      $display("circle_circle_contact_tb OK");
    end else begin
      $display("circle_circle_contact_tb NOT OK");
    end
    $finish;
  end

endmodule
